FILE: sv/nsbs_pkg.sv
// ----------------------------------------------------------------------------
// nsbs_pkg
// Shared types, constants and helpers for the noise filter-bank subtractor.
// ----------------------------------------------------------------------------
`default_nettype none
package nsbs_pkg;

   localparam int NSBS_BINS = 256;
   localparam int SUM_W = 48;

   localparam logic [8:0]  ACTIVE_RESET = 9'd0;
   localparam logic [15:0] THRESH_RESET = 16'd33;
   localparam logic [15:0] GAIN_RESET   = 16'd328;
   localparam logic [31:0] SEED_RESET   = 32'd1;

   localparam logic [1:0] REG_ACTIVE = 2'd0;
   localparam logic [1:0] REG_THRESH = 2'd1;
   localparam logic [1:0] REG_GAIN   = 2'd2;
   localparam logic [1:0] REG_SEED   = 2'd3;

   localparam logic FUNC_BIN_WRITE = 1'b0;
   localparam logic FUNC_TICK      = 1'b1;

   // bin entry: suppression in the low bits
   typedef struct packed {
      logic [15:0] damp;
      logic [15:0] freq;
      logic [15:0] supp;
   } bin_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bank_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      logic signed [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [44:0] x);
      logic signed [15:0] r;
      if (x > 45'sd32767) begin
         r = 16'sh7fff;
      end else if (x < -45'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/nsbs_bank.sv
// ----------------------------------------------------------------------------
// nsbs_bank
// Bin memories and the per-bin filter sequencer; accumulates weighted bands.
// ----------------------------------------------------------------------------
`default_nettype none
module nsbs_bank #(
   parameter int BINS = nsbs_pkg::NSBS_BINS,
   parameter int AW = (BINS > 1) ? $clog2(BINS) : 1,
   parameter int CW = $clog2(BINS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire nsbs_pkg::bin_entry_type        wr_data,
   input  wire logic                           start,
   input  wire logic [CW-1:0]                  count,
   input  wire logic signed [31:0]             noise,
   input  wire logic [15:0]                    threshold,
   output nsbs_pkg::bank_status_type           status,
   output logic signed [nsbs_pkg::SUM_W-1:0]   sum
);
   import nsbs_pkg::*;

   localparam logic [3:0] B_CLR  = 4'd0;
   localparam logic [3:0] B_IDLE = 4'd1;
   localparam logic [3:0] B_RD   = 4'd2;
   localparam logic [3:0] B_M1   = 4'd3;
   localparam logic [3:0] B_LOW  = 4'd4;
   localparam logic [3:0] B_HIGH = 4'd5;
   localparam logic [3:0] B_FH   = 4'd6;
   localparam logic [3:0] B_BAND = 4'd7;
   localparam logic [3:0] B_SB   = 4'd8;
   localparam logic [3:0] B_ACC  = 4'd9;

   bin_entry_type        wmem [0:BINS-1];
   logic [63:0]          smem [0:BINS-1];   // {band, low}

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 done_ff, done_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   bin_entry_type        rd_w_ff;
   logic [63:0]          rd_s_ff;
   logic signed [48:0]   fb_ff, qb_ff, fh_ff, sb_ff;
   logic signed [31:0]   low_ff, high_ff, band_ff;
   logic signed [33:0]   qbs_ff;

   logic [AW-1:0]        addr;
   logic                 last;
   logic                 clr_last;
   logic signed [31:0]   band_old, low_old, band_new;
   logic signed [16:0]   f_s, q_s, s_s;

   logic                 wm_we, sm_we;
   logic [AW-1:0]        wm_addr;
   bin_entry_type        wm_data;
   logic [63:0]          sm_data;

   assign addr     = idx_ff[AW-1:0];
   assign last     = (idx_ff + CW'(1)) == count;
   assign clr_last = idx_ff == CW'(BINS - 1);
   assign band_old = rd_s_ff[63:32];
   assign low_old  = rd_s_ff[31:0];
   assign f_s      = $signed({1'b0, rd_w_ff.freq});
   assign q_s      = $signed({1'b0, rd_w_ff.damp});
   assign s_s      = $signed({1'b0, rd_w_ff.supp});
   assign band_new = sat32(40'(fh_ff >>> 15) + 40'(band_old));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      done_in  = 1'b0;
      sum_in   = sum_ff;
      unique case (state_ff)
         B_CLR: begin
            idx_in = idx_ff + CW'(1);
            if (clr_last) begin
               state_in = B_IDLE;
               idx_in   = '0;
            end
         end
         B_IDLE: begin
            if (start) begin
               state_in = B_RD;
               idx_in   = '0;
               sum_in   = '0;
            end
         end
         B_RD: state_in = B_M1;
         B_M1: begin
            if (rd_w_ff.supp < threshold) begin
               idx_in = idx_ff + CW'(1);
               if (last) begin
                  state_in = B_IDLE;
                  done_in  = 1'b1;
               end else begin
                  state_in = B_RD;
               end
            end else begin
               state_in = B_LOW;
            end
         end
         B_LOW:  state_in = B_HIGH;
         B_HIGH: state_in = B_FH;
         B_FH:   state_in = B_BAND;
         B_BAND: state_in = B_SB;
         B_SB:   state_in = B_ACC;
         B_ACC: begin
            sum_in = sum_ff + SUM_W'(sb_ff >>> 15);
            idx_in = idx_ff + CW'(1);
            if (last) begin
               state_in = B_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = B_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLR;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
      sum_ff <= sum_in;
   end

   // clearing pass shares the write ports with bin writes and filter updates
   always_comb begin
      wm_we   = 1'b0;
      wm_addr = wr_addr;
      wm_data = wr_data;
      sm_we   = 1'b0;
      sm_data = {band_new, low_ff};
      if (state_ff == B_CLR) begin
         wm_we   = 1'b1;
         wm_addr = addr;
         wm_data = '0;
         sm_we   = 1'b1;
         sm_data = '0;
      end else if (wr_en) begin
         wm_we = 1'b1;
      end
      if (state_ff == B_BAND) begin
         sm_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wm_we) begin
         wmem[wm_addr] <= wm_data;
      end
      if (sm_we) begin
         smem[addr] <= sm_data;
      end
      rd_w_ff <= wmem[addr];
      rd_s_ff <= smem[addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_M1) begin
         fb_ff <= f_s * band_old;
         qb_ff <= q_s * band_old;
      end
      if (state_ff == B_LOW) begin
         low_ff <= sat32(40'(low_old) + 40'(fb_ff >>> 15));
         qbs_ff <= 34'(qb_ff >>> 15);
      end
      if (state_ff == B_HIGH) begin
         high_ff <= sat32(40'(noise) - 40'(low_ff) - 40'(qbs_ff));
      end
      if (state_ff == B_FH) begin
         fh_ff <= f_s * high_ff;
      end
      if (state_ff == B_BAND) begin
         band_ff <= band_new;
      end
      if (state_ff == B_SB) begin
         sb_ff <= s_s * band_ff;
      end
   end

   assign status.busy = (state_ff == B_CLR);
   assign status.done = done_ff;
   assign sum         = sum_ff;

endmodule
`default_nettype wire

FILE: sv/nsbs_post.sv
// ----------------------------------------------------------------------------
// nsbs_post
// Output scaling: difference times output gain times envelope, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module nsbs_post (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [31:0]            noise,
   input  wire logic signed [nsbs_pkg::SUM_W-1:0] sum,
   input  wire logic [15:0]                   gain,
   input  wire logic [15:0]                   env,
   output logic                               done,
   output logic signed [15:0]                 sample
);
   import nsbs_pkg::*;

   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [48:0]    diff_ff;
   logic signed [65:0]    m1_ff;
   logic signed [67:0]    m2_ff;
   logic signed [50:0]    m1s;
   logic signed [52:0]    m2s;

   assign m1s = 51'(m1_ff >>> 15);
   assign m2s = 53'(m2_ff >>> 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      diff_ff <= 49'(noise) - 49'(sum);
      m1_ff   <= diff_ff * $signed({1'b0, gain});
      m2_ff   <= m1s * $signed({1'b0, env});
   end

   assign done   = v3_ff;
   assign sample = sat16(45'(m2s >>> 8));

endmodule
`default_nettype wire

FILE: sv/noise_svf_bank_subtractor.sv
// ----------------------------------------------------------------------------
// noise_svf_bank_subtractor
// Xorshift noise minus a bank of Chamberlin band-pass filters, scaled out.
// ----------------------------------------------------------------------------
// Usage: req words with tuser = 0 load one bin entry (suppression, frequency
// and damping coefficients). A req word with tuser = 1 is a tick: it draws
// noise, steps every active bin at or above the threshold and yields one rsp
// word with the same sample on left and right.
// Flow: each bin is handled by one shared multiply/saturate datapath fed from
// the bin memories; a skipped bin stops after the threshold compare, and the
// bank sum then goes through output scaling. With no active bins a tick draws
// no noise and yields a zero sample. One item is in work at a time.
// The result sits in an output register; req_tready returns while it waits,
// but the next tick holds its result until rsp_tready takes the previous one.
// Reset: a clearing pass zeroes the bin and filter memories; req_tready
// stays low during it. CSR writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module noise_svf_bank_subtractor #(
   parameter int BINS = nsbs_pkg::NSBS_BINS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] bin_index, [23:8] suppression, [39:24] freq_coef,
   // [55:40] damping_coef, [71:56] env_gain
   input  wire logic [71:0] req_tdata,
   input  wire logic [0:0]  req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] left_sample, [31:16] right_sample
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import nsbs_pkg::*;

   localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int CW = $clog2(BINS + 1);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_BANK = 2'd1;
   localparam logic [1:0] T_POST = 2'd2;
   localparam logic [1:0] T_OUT  = 2'd3;

   logic [8:0]          active_ff;
   logic [15:0]         thresh_ff, gain_ff;
   logic [31:0]         seed_ff, noise_reg_ff;
   logic signed [31:0]  noise_ff;
   logic [15:0]         env_ff;
   logic [1:0]          state_ff, state_in;
   logic                start_ff;
   logic signed [15:0]  result_ff, result_in;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_sample_ff;

   logic                accept, is_tick, cfg_wr;
   logic [CW-1:0]       count;
   logic [31:0]         x1, x2, x3;
   logic [7:0]          bin_index;
   bin_entry_type       entry;
   logic                wr_en;
   bank_status_type     bank_st;
   logic signed [SUM_W-1:0] bank_sum;
   logic                post_done;
   logic signed [15:0]  post_sample;
   logic                out_free;

   assign bin_index  = req_tdata[7:0];
   assign entry.supp = req_tdata[23:8];
   assign entry.freq = req_tdata[39:24];
   assign entry.damp = req_tdata[55:40];

   assign req_tready = (state_ff == T_IDLE) && !bank_st.busy;
   assign accept     = req_tvalid && req_tready;
   assign is_tick    = (req_tuser[0] == FUNC_TICK);
   assign wr_en      = accept && (req_tuser[0] == FUNC_BIN_WRITE) &&
                       (32'(bin_index) < BINS);
   assign count      = (32'(active_ff) > BINS) ? CW'(BINS) : CW'(active_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign x1 = noise_reg_ff ^ (noise_reg_ff << 13);
   assign x2 = x1 ^ (x1 >> 17);
   assign x3 = x2 ^ (x2 << 5);

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ACTIVE: csr_prdata = {23'd0, active_ff};
         REG_THRESH: csr_prdata = {16'd0, thresh_ff};
         REG_GAIN:   csr_prdata = {16'd0, gain_ff};
         REG_SEED:   csr_prdata = seed_ff;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         thresh_ff    <= THRESH_RESET;
         gain_ff      <= GAIN_RESET;
         seed_ff      <= SEED_RESET;
         noise_reg_ff <= SEED_RESET;
      end else begin
         if (accept && is_tick && (count != '0)) begin
            noise_reg_ff <= x3;
         end
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_ACTIVE: active_ff <= csr_pwdata[8:0];
               REG_THRESH: thresh_ff <= csr_pwdata[15:0];
               REG_GAIN:   gain_ff   <= csr_pwdata[15:0];
               REG_SEED: begin
                  seed_ff      <= csr_pwdata;
                  noise_reg_ff <= csr_pwdata;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept && is_tick) begin
               if (count == '0) begin
                  state_in  = T_OUT;
                  result_in = '0;
               end else begin
                  state_in = T_BANK;
               end
            end
         end
         T_BANK: begin
            if (bank_st.done) begin
               state_in = T_POST;
            end
         end
         T_POST: begin
            if (post_done) begin
               state_in  = T_OUT;
               result_in = post_sample;
            end
         end
         T_OUT: begin
            if (out_free) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept && is_tick && (count != '0);
         if (state_ff == T_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      result_ff <= result_in;
      if (accept && is_tick) begin
         noise_ff <= $signed(x3) >>> 8;
         env_ff   <= req_tdata[71:56];
      end
      if (state_ff == T_OUT && out_free) begin
         rsp_sample_ff <= result_ff;
      end
   end

   nsbs_bank #(
      .BINS (BINS),
      .AW   (AW),
      .CW   (CW)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (AW'({{AW{1'b0}}, bin_index})),
      .wr_data   (entry),
      .start     (start_ff),
      .count     (count),
      .noise     (noise_ff),
      .threshold (thresh_ff),
      .status    (bank_st),
      .sum       (bank_sum)
   );

   nsbs_post u_post (
      .clock  (clock),
      .reset  (reset),
      .start  (bank_st.done && (state_ff == T_BANK)),
      .noise  (noise_ff),
      .sum    (bank_sum),
      .gain   (gain_ff),
      .env    (env_ff),
      .done   (post_done),
      .sample (post_sample)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sample_ff, rsp_sample_ff};

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the noise filter-bank subtractor.
// ----------------------------------------------------------------------------
// Bin writes and ticks are streamed into the block. A bit-exact software copy
// of the filter bank tracks each accepted tick and queues the sample it
// should produce; every rsp word is checked against the oldest queued sample.
// Directed extremes come first, then random phases under changing idle
// patterns and register settings, and last a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import nsbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   noise_svf_bank_subtractor u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // bank model state
   logic [8:0]  mdl_active;
   logic [15:0] mdl_thresh;
   logic [15:0] mdl_gain;
   logic [31:0] mdl_noise;
   int          low_st [NSBS_BINS];
   int          band_st [NSBS_BINS];
   logic [15:0] supp_w [NSBS_BINS];
   logic [15:0] freq_w [NSBS_BINS];
   logic [15:0] damp_w [NSBS_BINS];

   logic [15:0] expected_samples [$];
   int          errors = 0;
   int          cycles = 0;
   int          ticks_sent = 0;
   int          bin_writes = 0;
   int          samples_checked = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          recv_hold = 0;

   function automatic int clamp32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return int'(x);
   endfunction

   function automatic longint q15_scale(logic [15:0] c, longint x);
      longint cv;
      cv = longint'({48'd0, c});
      return (cv * x) >>> 15;
   endfunction

   // advances the bank by one tick and returns the expected sample
   function automatic logic [15:0] bank_tick(logic [15:0] env);
      int     n, lo, bd, hi;
      longint noise, sum, v;
      n = (mdl_active > NSBS_BINS) ? NSBS_BINS : int'(mdl_active);
      if (n == 0) return 16'd0;
      mdl_noise = mdl_noise ^ (mdl_noise << 13);
      mdl_noise = mdl_noise ^ (mdl_noise >> 17);
      mdl_noise = mdl_noise ^ (mdl_noise << 5);
      noise = longint'(int'(mdl_noise)) >>> 8;
      sum = 0;
      for (int b = 0; b < n; b++) begin
         if (supp_w[b] < mdl_thresh) continue;
         bd = band_st[b];
         lo = clamp32(longint'(low_st[b]) + q15_scale(freq_w[b], bd));
         hi = clamp32(noise - longint'(lo) - q15_scale(damp_w[b], bd));
         bd = clamp32(q15_scale(freq_w[b], hi) + longint'(bd));
         low_st[b] = lo;
         band_st[b] = bd;
         sum += q15_scale(supp_w[b], bd);
      end
      v = q15_scale(mdl_gain, noise - sum);
      v = q15_scale(env, v) >>> 8;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected rsp word %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            logic [15:0] exp_s;
            exp_s = expected_samples.pop_front();
            samples_checked++;
            if (rsp_tdata[15:0] !== exp_s) begin
               $display("%0t: left_sample expected %h actual %h",
                        $realtime, exp_s, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== exp_s) begin
               $display("%0t: right_sample expected %h actual %h",
                        $realtime, exp_s, rsp_tdata[31:16]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ACTIVE: mdl_active = val[8:0];
         REG_THRESH: mdl_thresh = val[15:0];
         REG_GAIN:   mdl_gain = val[15:0];
         REG_SEED:   mdl_noise = val;
         default: ;
      endcase
   endtask

   task automatic send_word(logic func, logic [7:0] idx, logic [15:0] supp,
                            logic [15:0] freq, logic [15:0] damp,
                            logic [15:0] env);
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {env, damp, freq, supp, idx};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_TICK) begin
         expected_samples.push_back(bank_tick(env));
         ticks_sent++;
      end else begin
         supp_w[idx] = supp;
         freq_w[idx] = freq;
         damp_w[idx] = damp;
         bin_writes++;
      end
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // wait for every queued sample, then let trailing bin writes settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic rand_bin(int span);
      logic [15:0] s;
      case ($urandom_range(0, 3))
         0: s = 16'($urandom_range(0, 65535));
         1: s = 16'd0;
         default: s = 16'($urandom_range(0, 32768));
      endcase
      send_word(FUNC_BIN_WRITE,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, span - 1)),
                s, 16'($urandom_range(0, 65535)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 40000)),
                16'($urandom_range(0, 65535)));
   endtask

   task automatic test_directed();
      csr_write(REG_GAIN, 32'd32768);
      csr_write(REG_THRESH, 32'd0);
      csr_write(REG_SEED, 32'hffffffff);
      // silent bank
      send_word(FUNC_TICK, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      drain();
      csr_write(REG_ACTIVE, 32'd4);
      send_word(FUNC_BIN_WRITE, 8'd0, 16'd32768, 16'd65535, 16'd65535, 16'd0);
      send_word(FUNC_BIN_WRITE, 8'd1, 16'd65535, 16'd0, 16'd0, 16'd0);
      send_word(FUNC_BIN_WRITE, 8'd2, 16'd0, 16'd12000, 16'd20000, 16'd0);
      send_word(FUNC_BIN_WRITE, 8'd3, 16'd33, 16'd40000, 16'd1, 16'd0);
      send_word(FUNC_BIN_WRITE, 8'd255, 16'd32768, 16'd1000, 16'd1000, 16'd0);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd65535);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      // rewrite keeps filter state
      send_word(FUNC_BIN_WRITE, 8'd0, 16'd32768, 16'd30000, 16'd500, 16'd0);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      drain();
      csr_write(REG_THRESH, 32'd32768);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      drain();
      csr_write(REG_THRESH, 32'd65535);
      csr_write(REG_SEED, 32'd0);   // generator stuck at zero
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      drain();
      csr_write(REG_THRESH, 32'd33);
      csr_write(REG_SEED, 32'h80000000);
      csr_write(REG_ACTIVE, 32'd511);   // clamps to the full bank
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      drain();
      csr_write(REG_ACTIVE, 32'd256);
      csr_write(REG_GAIN, 32'd0);
      send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
      drain();
   endtask

   task automatic test_random(int n_items, int s_idle, int r_idle);
      int span;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            drain();
            span = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 12);
            csr_write(REG_ACTIVE, ($urandom_range(0, 12) == 0) ? 0 : span);
            csr_write(REG_THRESH, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 65535) : $urandom_range(0, 40));
            csr_write(REG_GAIN, $urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0)
               csr_write(REG_SEED, $urandom());
         end
         if (span == 256 && $urandom_range(0, 4) != 0)
            rand_bin(span);
         else if ($urandom_range(0, 1) == 0)
            rand_bin(span);
         else
            send_word(FUNC_TICK, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 32768)));
      end
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_ACTIVE, 32'd3);
      csr_write(REG_THRESH, 32'd0);
      recv_hold = 400;
      for (int i = 0; i < 8; i++)
         send_word(FUNC_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 65535)));
      drain();
   endtask

   initial begin
      mdl_active = ACTIVE_RESET;
      mdl_thresh = THRESH_RESET;
      mdl_gain = GAIN_RESET;
      mdl_noise = SEED_RESET;
      for (int b = 0; b < NSBS_BINS; b++) begin
         low_st[b] = 0;
         band_st[b] = 0;
         supp_w[b] = '0;
         freq_w[b] = '0;
         damp_w[b] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200, 22, 73);
      test_random(200, 73, 22);
      test_random(220, 0, 0);
      test_backpressure();
      $display("covered %0d bin writes and %0d ticks, %0d samples checked",
               bin_writes, ticks_sent, samples_checked);
      $display("settings swept: silent and full bank, threshold/gain/seed extremes");
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
